[hdl/assert_macros.svh]
// Assertion macros used by the cache top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

`endif

[hdl/lcc_pkg.sv]
// Types and constants for the LRU checksum cache.
`timescale 1ns / 1ps
package lcc_pkg;

   localparam int CONTAINER_W = 32;
   localparam int OBJECT_W    = 64;
   localparam int OFFSET_W    = 48;
   localparam int DATA_W      = 64;
   localparam int MODE_W      = 2;
   localparam int CAP_W       = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // cells per reduction group
   localparam int GRP_SIZE = 32;

   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INVAL  = 2'd2;

   typedef struct packed {
      logic [CONTAINER_W-1:0] container;
      logic [OBJECT_W-1:0]    object;
      logic [OFFSET_W-1:0]    offset;
   } key_type;

   typedef struct packed {
      key_type             key;
      logic [DATA_W-1:0]   checksum;
      logic [DATA_W-1:0]   sparse;
   } slot_type;

   typedef struct packed {
      logic take_prev;   // load from the newer neighbor (front input for cell 0)
      logic take_next;   // load from the older neighbor
      logic clear;       // drop this entry after the move
   } cell_ctrl_type;

endpackage

[hdl/lcc_cell.sv]
// One cache slot of the recency chain: entry storage, key compare and neighbor moves.
`timescale 1ns / 1ps
module lcc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  compare_en,
   input  lcc_pkg::key_type      cmp_key,
   input  lcc_pkg::cell_ctrl_type ctrl,
   input  logic                  prev_valid,
   input  lcc_pkg::slot_type     prev_slot,
   input  logic                  next_valid,
   input  lcc_pkg::slot_type     next_slot,
   output logic                  valid,
   output lcc_pkg::slot_type     slot,
   output logic                  match
);
   import lcc_pkg::*;

   logic     valid_ff, valid_in;
   slot_type slot_ff, slot_in;
   logic     match_ff, match_in;

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (ctrl.take_prev) begin
         valid_in = prev_valid;
         slot_in  = prev_slot;
      end else if (ctrl.take_next) begin
         valid_in = next_valid;
         slot_in  = next_slot;
      end
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end
      match_in = match_ff;
      if (compare_en) begin
         match_in = valid_ff && (slot_ff.key == cmp_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign valid = valid_ff;
   assign slot  = slot_ff;
   assign match = match_ff;

endmodule

[hdl/lru_checksum_cache_top.sv]
// Top level of the LRU checksum cache: request control, match reduction and cell chain.
// Sequence: a request beat is compared in every cell as it is taken, match and hit data
// are reduced the next cycle, and the chain shifts with the response loaded in the update state.
// A new request is stalled until the current one leaves the update state; a
// stalled response holds the shift until the response register frees.
// Reset (synchronous): all cells invalid, count zero, capacity 1024; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lru_checksum_cache_top #(
   parameter int ENTRIES = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [lcc_pkg::CAP_W-1:0]       csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lcc_pkg::MODE_W-1:0]      req_mode,
   input  logic [lcc_pkg::CONTAINER_W-1:0] req_container_tag,
   input  logic [lcc_pkg::OBJECT_W-1:0]    req_object_tag,
   input  logic [lcc_pkg::OFFSET_W-1:0]    req_offset,
   input  logic [lcc_pkg::DATA_W-1:0]      req_checksum_in,
   input  logic [lcc_pkg::DATA_W-1:0]      req_sparse_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [lcc_pkg::DATA_W-1:0]      rsp_checksum_out,
   output logic [lcc_pkg::DATA_W-1:0]      rsp_sparse_out
);
   import lcc_pkg::*;

   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int LEVELS = $clog2(ENTRIES);
   localparam int GROUPS = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
   localparam int PADDED = GROUPS * GRP_SIZE;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [MODE_W-1:0] mode_ff;
   key_type           key_ff;
   logic [DATA_W-1:0] cks_ff, spa_ff;

   logic accept, commit, need_rsp, hit;
   logic rsp_fire;
   key_type req_key;

   // chain signals
   logic [ENTRIES-1:0] cell_valid;
   logic [ENTRIES-1:0] match_vec;
   slot_type           cell_slot [ENTRIES];
   cell_ctrl_type      cell_ctrl [ENTRIES];
   slot_type           front_slot;

   // reduction
   logic [DATA_W-1:0]  masked_cks [PADDED];
   logic [DATA_W-1:0]  masked_spa [PADDED];
   logic [DATA_W-1:0]  grp_cks_ff [GROUPS];
   logic [DATA_W-1:0]  grp_spa_ff [GROUPS];
   logic [DATA_W-1:0]  grp_cks_in [GROUPS];
   logic [DATA_W-1:0]  grp_spa_in [GROUPS];
   logic [GROUPS-1:0]  grp_hit_ff, grp_hit_in;
   logic [ENTRIES-1:0] above_ff, above_in;   // a match at this cell or older
   logic [ENTRIES-1:0] below_ff, below_in;   // a match at this cell or newer
   logic [DATA_W-1:0]  hit_cks, hit_spa;

   // update control
   logic shift_old_en, shift_all, shift_new_en;
   logic evict_en;
   logic [CNT_W-1:0] cnt_new, cnt_dec;
   logic [IDX_W-1:0] evict_idx;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [DATA_W-1:0] rsp_cks_ff, rsp_spa_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;

   assign req_key.container = req_container_tag;
   assign req_key.object    = req_object_tag;
   assign req_key.offset    = req_offset;

   assign need_rsp = (mode_ff == MODE_LOOKUP) || (mode_ff == MODE_INVAL);
   assign commit   = (state_ff == ST_UPDATE) && (!need_rsp || !rsp_valid_ff || !rsp_stall);
   assign hit      = |grp_hit_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            state_in = accept ? ST_REDUCE : ST_IDLE;
         end
         ST_REDUCE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = commit ? ST_IDLE : ST_UPDATE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         capacity_ff <= CAP_RESET;
         count_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
         cks_ff  <= req_checksum_in;
         spa_ff  <= req_sparse_in;
      end
   end

   // ---------------- cell chain ----------------
   assign front_slot.key      = key_ff;
   assign front_slot.checksum = (mode_ff == MODE_LOOKUP) ? hit_cks : cks_ff;
   assign front_slot.sparse   = (mode_ff == MODE_LOOKUP) ? hit_spa : spa_ff;

   assign shift_old_en = ((mode_ff == MODE_LOOKUP) && hit) || (mode_ff == MODE_INSERT);
   assign shift_all    = (mode_ff == MODE_INSERT) && !hit;
   assign shift_new_en = (mode_ff == MODE_INVAL) && hit;

   genvar i;
   generate
      for (i = 0; i < ENTRIES; i++) begin : g_cell
         logic     prev_v, next_v;
         slot_type prev_s, next_s;

         if (i == 0) begin : g_front
            assign prev_v = 1'b1;
            assign prev_s = front_slot;
         end else begin : g_mid_prev
            assign prev_v = cell_valid[i-1];
            assign prev_s = cell_slot[i-1];
         end
         if (i == ENTRIES - 1) begin : g_tail
            assign next_v = 1'b0;
            assign next_s = front_slot;
         end else begin : g_mid_next
            assign next_v = cell_valid[i+1];
            assign next_s = cell_slot[i+1];
         end

         assign cell_ctrl[i].take_prev = commit && shift_old_en && (shift_all || above_ff[i]);
         assign cell_ctrl[i].take_next = commit && shift_new_en && below_ff[i];
         assign cell_ctrl[i].clear     = commit && evict_en && (IDX_W'(i) == evict_idx);

         lcc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .compare_en (accept),
            .cmp_key    (req_key),
            .ctrl       (cell_ctrl[i]),
            .prev_valid (prev_v),
            .prev_slot  (prev_s),
            .next_valid (next_v),
            .next_slot  (next_s),
            .valid      (cell_valid[i]),
            .slot       (cell_slot[i]),
            .match      (match_vec[i])
         );
      end

      for (i = 0; i < PADDED; i++) begin : g_mask
         if (i < ENTRIES) begin : g_real
            assign masked_cks[i] = match_vec[i] ? cell_slot[i].checksum : '0;
            assign masked_spa[i] = match_vec[i] ? cell_slot[i].sparse : '0;
         end else begin : g_pad
            assign masked_cks[i] = '0;
            assign masked_spa[i] = '0;
         end
      end
   endgenerate

   // ---------------- match reduction ----------------
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_cks_in[g] = '0;
         grp_spa_in[g] = '0;
         grp_hit_in[g] = 1'b0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            grp_cks_in[g] = grp_cks_in[g] | masked_cks[g*GRP_SIZE + j];
            grp_spa_in[g] = grp_spa_in[g] | masked_spa[g*GRP_SIZE + j];
            if (g*GRP_SIZE + j < ENTRIES) begin
               grp_hit_in[g] = grp_hit_in[g] | match_vec[g*GRP_SIZE + j];
            end
         end
      end
      // log-depth suffix and prefix OR of the match vector
      above_in = match_vec;
      below_in = match_vec;
      for (int k = 0; k < LEVELS; k++) begin
         above_in = above_in | (above_in >> (1 << k));
         below_in = below_in | (below_in << (1 << k));
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_REDUCE) begin
         grp_hit_ff <= grp_hit_in;
         above_ff   <= above_in;
         below_ff   <= below_in;
         for (int g = 0; g < GROUPS; g++) begin
            grp_cks_ff[g] <= grp_cks_in[g];
            grp_spa_ff[g] <= grp_spa_in[g];
         end
      end
   end

   always_comb begin
      hit_cks = '0;
      hit_spa = '0;
      for (int g = 0; g < GROUPS; g++) begin
         hit_cks = hit_cks | grp_cks_ff[g];
         hit_spa = hit_spa | grp_spa_ff[g];
      end
   end

   // ---------------- entry count and eviction ----------------
   always_comb begin
      cnt_new  = count_ff;
      evict_en = 1'b0;
      count_in = count_ff;
      case (mode_ff)
         MODE_INSERT: begin
            if (!hit && (count_ff != CNT_W'(ENTRIES))) begin
               cnt_new = count_ff + 1'b1;
            end
            // a full store drops its oldest entry through the shift itself
            evict_en = (hit || (count_ff != CNT_W'(ENTRIES))) &&
                       (CMP_W'(cnt_new) > CMP_W'(capacity_ff));
            if (commit) begin
               count_in = evict_en ? (cnt_new - 1'b1) : cnt_new;
            end
         end
         MODE_INVAL: begin
            if (commit && hit) begin
               count_in = count_ff - 1'b1;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      cnt_dec   = cnt_new - 1'b1;
      evict_idx = cnt_dec[IDX_W-1:0];
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (commit && need_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit && need_rsp) begin
         rsp_found_ff <= hit;
         if ((mode_ff == MODE_LOOKUP) && hit) begin
            rsp_cks_ff <= hit_cks;
            rsp_spa_ff <= hit_spa;
         end else begin
            rsp_cks_ff <= '0;
            rsp_spa_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_checksum_out = rsp_cks_ff;
   assign rsp_sparse_out   = rsp_spa_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLY(a_match_unique, clock, reset, state_ff == ST_UPDATE, $onehot0(match_vec))
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(ENTRIES))
   `ASSERT_ALWAYS(a_front_valid, clock, reset, cell_valid[0] == (count_ff != '0))
   `ASSERT_IMPLY(a_rsp_from_update, clock, reset, rsp_valid_ff && !$past(rsp_valid_ff), $past(state_ff) == ST_UPDATE)

endmodule
